@@ sv/tjm_pkg.sv @@
// Shared widths, types and codes for the touch joystick mapper.
// No dependencies.
package tjm_pkg;

    localparam int COORD_BITS = 12;
    localparam int KR_BITS    = COORD_BITS - 1;
    localparam int DXW        = COORD_BITS + 3;
    localparam int AW         = COORD_BITS + 2;
    localparam int SQW        = 2 * AW + 1;
    localparam int SIN        = ((SQW + 16) % 2 == 0) ? (SQW + 16) : (SQW + 17);
    localparam int RB         = SIN / 2;
    localparam int QB         = 17;
    localparam int NW         = AW + 25;
    localparam int DW         = RB + 1;
    localparam int KW         = 14;
    localparam int AXW        = 16;
    localparam int CIW        = 3;
    localparam int SQ_RW      = RB + 3;
    localparam int DIV_WW     = (NW > DW + QB) ? NW : (DW + QB);

    localparam logic [AXW-2:0] MAG_MAX = '1;

    typedef enum logic [1:0] {
        ZONE_NONE = 2'd0,
        ZONE_IN   = 2'd1,
        ZONE_RING = 2'd2,
        ZONE_OUT  = 2'd3
    } t_zone;

    typedef enum logic [CIW-1:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_BOX_W    = 3'd2,
        CFG_KNOB_R   = 3'd3,
        CFG_RING_W   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [COORD_BITS-1:0] origin_x;
        logic [COORD_BITS-1:0] origin_y;
        logic [COORD_BITS-1:0] box_width;
        logic [KR_BITS-1:0]    knob_radius;
        logic [COORD_BITS-1:0] ring_width;
    } t_cfg;

    typedef struct packed {
        logic          valid;
        t_zone         zone;
        logic          neg_x;
        logic          neg_y;
        logic [AW-1:0] ax;
        logic [AW-1:0] ay;
        logic [KW-1:0] knob_x;
        logic [KW-1:0] knob_y;
    } t_side;

endpackage

@@ sv/tjm_front.sv @@
// Front end: offsets, squares, squared distance and zone, three stages.
// Depends on tjm_pkg.
module tjm_front import tjm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_touch_active,
    input  logic [COORD_BITS-1:0] i_touch_x,
    input  logic [COORD_BITS-1:0] i_touch_y,
    input  t_cfg                  i_cfg,
    output t_side                 o_side,
    output logic [SQW-1:0]        o_d2sq
);

    logic                  r_v1, r_act1;
    logic signed [DXW-1:0] r_dx1, r_dy1;
    logic [KW-1:0]         r_ktx1, r_kty1, r_kc1;

    logic                  r_v2, r_act2, r_negx2, r_negy2;
    logic [AW-1:0]         r_ax2, r_ay2;
    logic [2*AW-1:0]       r_axsq2, r_aysq2;
    logic [2*AW-1:0]       r_rin2, r_rout2;
    logic [KW-1:0]         r_ktx2, r_kty2, r_kc2;

    logic signed [DXW-1:0] n_dx, n_dy;
    logic [AW-1:0]         n_ax, n_ay, n_rout;
    logic [SQW-1:0]        n_d2sq;
    t_zone                 n_zone;
    t_side                 n_side, r_side;
    logic [SQW-1:0]        r_d2sq;

    always_comb begin
        n_dx = DXW'({2'b0, i_touch_x, 1'b0}) - DXW'({2'b0, i_cfg.origin_x, 1'b0})
             - DXW'({3'b0, i_cfg.box_width});
        n_dy = DXW'({2'b0, i_touch_y, 1'b0}) - DXW'({2'b0, i_cfg.origin_y, 1'b0})
             - DXW'({3'b0, i_cfg.box_width});
        n_ax = r_dx1[DXW-1] ? AW'(-r_dx1) : AW'(r_dx1);
        n_ay = r_dy1[DXW-1] ? AW'(-r_dy1) : AW'(r_dy1);
        n_rout = AW'(i_cfg.box_width) + AW'({i_cfg.ring_width, 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_act1 <= i_touch_active;
        r_dx1  <= n_dx;
        r_dy1  <= n_dy;
        r_ktx1 <= KW'(i_touch_x) - KW'(i_cfg.origin_x) - KW'(i_cfg.knob_radius);
        r_kty1 <= KW'(i_touch_y) - KW'(i_cfg.origin_y) - KW'(i_cfg.knob_radius);
        r_kc1  <= KW'(i_cfg.box_width >> 1) - KW'(i_cfg.knob_radius);

        r_act2  <= r_act1;
        r_negx2 <= r_dx1 < 0;
        r_negy2 <= r_dy1 > 0;
        r_ax2   <= n_ax;
        r_ay2   <= n_ay;
        r_axsq2 <= n_ax * n_ax;
        r_aysq2 <= n_ay * n_ay;
        r_rin2  <= (2*AW)'(i_cfg.box_width) * (2*AW)'(i_cfg.box_width);
        r_rout2 <= n_rout * n_rout;
        r_ktx2  <= r_ktx1;
        r_kty2  <= r_kty1;
        r_kc2   <= r_kc1;
    end

    always_comb begin
        n_d2sq = SQW'(r_axsq2) + SQW'(r_aysq2);
        if (!r_act2) begin
            n_zone = ZONE_NONE;
        end else if (n_d2sq < SQW'(r_rin2)) begin
            n_zone = ZONE_IN;
        end else if (n_d2sq <= SQW'(r_rout2)) begin
            n_zone = ZONE_RING;
        end else begin
            n_zone = ZONE_OUT;
        end
        n_side.valid = r_v2;
        n_side.zone  = n_zone;
        n_side.neg_x = r_negx2;
        n_side.neg_y = r_negy2;
        n_side.ax    = r_ax2;
        n_side.ay    = r_ay2;
        if (n_zone == ZONE_IN || n_zone == ZONE_RING) begin
            n_side.knob_x = r_ktx2;
            n_side.knob_y = r_kty2;
        end else begin
            n_side.knob_x = r_kc2;
            n_side.knob_y = r_kc2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else begin
            r_side <= n_side;
        end
        r_d2sq <= n_d2sq;
    end

    assign o_side = r_side;
    assign o_d2sq = r_d2sq;

endmodule

@@ sv/tjm_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on tjm_pkg.
module tjm_sqrt import tjm_pkg::*; (
    input  logic           i_clk,
    input  logic [SIN-1:0] i_val,
    output logic [RB-1:0]  o_root
);

    logic [SQ_RW-1:0] r_rem  [RB];
    logic [RB-1:0]    r_root [RB];
    logic [SIN-1:0]   r_src  [RB];

    genvar k;
    generate
        for (k = 0; k < RB; k++) begin : g_stage
            logic [SQ_RW-1:0] w_rem_in, w_t, w_trial;
            logic [RB-1:0]    w_root_in;
            logic [SIN-1:0]   w_src_in;

            if (k == 0) begin : g_first
                assign w_rem_in  = '0;
                assign w_root_in = '0;
                assign w_src_in  = i_val;
            end else begin : g_next
                assign w_rem_in  = r_rem[k-1];
                assign w_root_in = r_root[k-1];
                assign w_src_in  = r_src[k-1];
            end

            assign w_t     = {w_rem_in[SQ_RW-3:0], w_src_in[SIN-1:SIN-2]};
            assign w_trial = SQ_RW'({w_root_in, 2'b01});

            always_ff @(posedge i_clk) begin
                if (w_t >= w_trial) begin
                    r_rem[k]  <= w_t - w_trial;
                    r_root[k] <= {w_root_in[RB-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= w_t;
                    r_root[k] <= {w_root_in[RB-2:0], 1'b0};
                end
                r_src[k] <= w_src_in << 2;
            end
        end
    endgenerate

    assign o_root = r_root[RB-1];

endmodule

@@ sv/tjm_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on tjm_pkg.
module tjm_div import tjm_pkg::*; (
    input  logic          i_clk,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QB-1:0] o_quo
);

    logic [DIV_WW-1:0] r_rem [QB];
    logic [DW-1:0]     r_den [QB];
    logic [QB-1:0]     r_quo [QB];

    genvar k;
    generate
        for (k = 0; k < QB; k++) begin : g_stage
            logic [DIV_WW-1:0] w_rem_in, w_sh;
            logic [DW-1:0]     w_den_in;
            logic [QB-1:0]     w_quo_in;

            if (k == 0) begin : g_first
                assign w_rem_in = DIV_WW'(i_num);
                assign w_den_in = i_den;
                assign w_quo_in = '0;
            end else begin : g_next
                assign w_rem_in = r_rem[k-1];
                assign w_den_in = r_den[k-1];
                assign w_quo_in = r_quo[k-1];
            end

            assign w_sh = DIV_WW'(w_den_in) << (QB - 1 - k);

            always_ff @(posedge i_clk) begin
                if (w_rem_in >= w_sh) begin
                    r_rem[k] <= w_rem_in - w_sh;
                    r_quo[k] <= w_quo_in | (QB'(1) << (QB - 1 - k));
                end else begin
                    r_rem[k] <= w_rem_in;
                    r_quo[k] <= w_quo_in;
                end
                r_den[k] <= w_den_in;
            end
        end
    endgenerate

    assign o_quo = r_quo[QB-1];

endmodule

@@ sv/touch_joystick_mapper_top.sv @@
// Touch joystick mapper top: config registers, front end, square root,
// two dividers, output register. Depends on tjm_pkg and all tjm_ modules.
//
// Channel   Handshake                  Payload
// input     start / busy               i_touch_active, i_touch_x, i_touch_y
// config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
// result    o_done (strobe)            o_zone, o_warning, o_knob_*, o_axis_*
//
// One sample per cycle; busy stays low. Each result passes the front end, the
// bit-per-stage root and divider, and the output register.
// Synchronous active-low reset clears valid bits and loads register defaults.
// No stalls on either side: o_done is high for one cycle per result.
module touch_joystick_mapper_top import tjm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_touch_active,
    input  logic [COORD_BITS-1:0] i_touch_x,
    input  logic [COORD_BITS-1:0] i_touch_y,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CIW-1:0]        i_cfg_index,
    input  logic [COORD_BITS-1:0] i_cfg_data,
    output logic                  o_done,
    output logic [1:0]            o_zone,
    output logic                  o_warning,
    output logic signed [KW-1:0]  o_knob_x,
    output logic signed [KW-1:0]  o_knob_y,
    output logic signed [AXW-1:0] o_axis_x,
    output logic signed [AXW-1:0] o_axis_y
);

    t_cfg           r_cfg;
    t_side          w_side;
    logic [SQW-1:0] w_d2sq;
    logic [RB-1:0]  w_root;
    t_side          r_sd [RB];
    t_side          r_se [QB];
    t_side          w_s, w_e;
    logic [NW-1:0]  n_num_x, n_num_y;
    logic [DW-1:0]  n_den;
    logic [QB-1:0]  w_qx, w_qy;
    logic [AXW-2:0] n_mx, n_my;
    logic           n_zero;

    logic                  r_done, r_warn;
    logic [1:0]            r_zone;
    logic [KW-1:0]         r_kx, r_ky;
    logic [AXW-1:0]        r_axx, r_axy;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x    <= '0;
            r_cfg.origin_y    <= '0;
            r_cfg.box_width   <= COORD_BITS'(100);
            r_cfg.knob_radius <= KR_BITS'(10);
            r_cfg.ring_width  <= COORD_BITS'(10);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ORIGIN_X: r_cfg.origin_x    <= i_cfg_data;
                CFG_ORIGIN_Y: r_cfg.origin_y    <= i_cfg_data;
                CFG_BOX_W:    r_cfg.box_width   <= i_cfg_data;
                CFG_KNOB_R:   r_cfg.knob_radius <= i_cfg_data[KR_BITS-1:0];
                CFG_RING_W:   r_cfg.ring_width  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tjm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (start && !busy),
        .i_touch_active (i_touch_active),
        .i_touch_x      (i_touch_x),
        .i_touch_y      (i_touch_y),
        .i_cfg          (r_cfg),
        .o_side         (w_side),
        .o_d2sq         (w_d2sq)
    );

    tjm_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_val  (SIN'({w_d2sq, 16'b0})),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RB; i++) r_sd[i] <= '0;
            for (int i = 0; i < QB; i++) r_se[i] <= '0;
        end else begin
            r_sd[0] <= w_side;
            for (int i = 1; i < RB; i++) r_sd[i] <= r_sd[i-1];
            r_se[0] <= r_sd[RB-1];
            for (int i = 1; i < QB; i++) r_se[i] <= r_se[i-1];
        end
    end

    assign w_s = r_sd[RB-1];
    assign w_e = r_se[QB-1];

    always_comb begin
        if (w_s.zone == ZONE_IN) begin
            n_num_x = NW'({w_s.ax, 16'b0}) + NW'(r_cfg.box_width);
            n_num_y = NW'({w_s.ay, 16'b0}) + NW'(r_cfg.box_width);
            n_den   = DW'({r_cfg.box_width, 1'b0});
        end else begin
            n_num_x = NW'({w_s.ax, 24'b0}) + NW'(w_root);
            n_num_y = NW'({w_s.ay, 24'b0}) + NW'(w_root);
            n_den   = DW'({w_root, 1'b0});
        end
    end

    tjm_div u_div_x (
        .i_clk (i_clk),
        .i_num (n_num_x),
        .i_den (n_den),
        .o_quo (w_qx)
    );

    tjm_div u_div_y (
        .i_clk (i_clk),
        .i_num (n_num_y),
        .i_den (n_den),
        .o_quo (w_qy)
    );

    always_comb begin
        n_zero = !(w_e.zone == ZONE_IN || w_e.zone == ZONE_RING)
               || (w_e.zone == ZONE_RING && w_e.ax == '0 && w_e.ay == '0);
        n_mx = (w_qx > QB'(MAG_MAX)) ? MAG_MAX : w_qx[AXW-2:0];
        n_my = (w_qy > QB'(MAG_MAX)) ? MAG_MAX : w_qy[AXW-2:0];
        if (n_zero) begin
            n_mx = '0;
            n_my = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_e.valid;
        end
        r_zone <= w_e.zone;
        r_warn <= (w_e.zone == ZONE_RING);
        r_kx   <= w_e.knob_x;
        r_ky   <= w_e.knob_y;
        r_axx  <= w_e.neg_x ? AXW'(-{1'b0, n_mx}) : {1'b0, n_mx};
        r_axy  <= w_e.neg_y ? AXW'(-{1'b0, n_my}) : {1'b0, n_my};
    end

    assign o_done    = r_done;
    assign o_zone    = r_zone;
    assign o_warning = r_warn;
    assign o_knob_x  = r_kx;
    assign o_knob_y  = r_ky;
    assign o_axis_x  = r_axx;
    assign o_axis_y  = r_axy;

endmodule

@@ verif/touch_joystick_mapper_top_tb.sv @@
// Self-checking testbench for touch_joystick_mapper_top: random and directed touch beats,
// several register settings, predictor-based checking of every result strobe.
// Depends on tjm_pkg and the mapper RTL.
`timescale 1ns / 100ps

module touch_joystick_mapper_top_tb;
    import tjm_pkg::*;

    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        bit                    active;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } t_touch;

    typedef struct {
        t_zone         zone;
        logic          warning;
        logic [KW-1:0] knob_x;
        logic [KW-1:0] knob_y;
        logic [AXW-1:0] axis_x;
        logic [AXW-1:0] axis_y;
    } t_joy;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_touch_active = 1'b0;
    logic [COORD_BITS-1:0] i_touch_x = '0;
    logic [COORD_BITS-1:0] i_touch_y = '0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CIW-1:0]        i_cfg_index = '0;
    logic [COORD_BITS-1:0] i_cfg_data = '0;
    logic                  o_done;
    logic [1:0]            o_zone;
    logic                  o_warning;
    logic signed [KW-1:0]  o_knob_x;
    logic signed [KW-1:0]  o_knob_y;
    logic signed [AXW-1:0] o_axis_x;
    logic signed [AXW-1:0] o_axis_y;

    touch_joystick_mapper_top DUT (.*);

    t_cfg   cur_cfg;
    t_touch touch_q[$];
    t_joy   joy_q[$];
    int     gap_left = 0;
    int     mismatches = 0;
    int     n_results = 0;
    int     n_ring = 0;
    int     n_phases = 0;
    longint cycles = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned clip_mag(longint unsigned m);
        return (m > 32767) ? 32767 : m;
    endfunction

    function automatic t_joy map_touch(t_touch t);
        longint dx2, dy2;
        longint unsigned ax, ay, d2sq, rin, rout, r, mx, my;
        t_joy e;
        dx2 = 2 * longint'(t.x) - (2 * longint'(cur_cfg.origin_x) + cur_cfg.box_width);
        dy2 = 2 * longint'(t.y) - (2 * longint'(cur_cfg.origin_y) + cur_cfg.box_width);
        ax = (dx2 < 0) ? -dx2 : dx2;
        ay = (dy2 < 0) ? -dy2 : dy2;
        d2sq = ax * ax + ay * ay;
        rin = cur_cfg.box_width;
        rout = rin + 2 * longint'(cur_cfg.ring_width);
        mx = 0;
        my = 0;
        e.warning = 1'b0;
        if (!t.active) e.zone = ZONE_NONE;
        else if (d2sq < rin * rin) e.zone = ZONE_IN;
        else if (d2sq <= rout * rout) e.zone = ZONE_RING;
        else e.zone = ZONE_OUT;
        if (e.zone == ZONE_IN || e.zone == ZONE_RING) begin
            e.knob_x = KW'(longint'(t.x) - cur_cfg.origin_x - cur_cfg.knob_radius);
            e.knob_y = KW'(longint'(t.y) - cur_cfg.origin_y - cur_cfg.knob_radius);
        end else begin
            e.knob_x = KW'(longint'(cur_cfg.box_width >> 1) - cur_cfg.knob_radius);
            e.knob_y = e.knob_x;
        end
        if (e.zone == ZONE_IN) begin
            mx = clip_mag((2 * ax * 32768 + rin) / (2 * rin));
            my = clip_mag((2 * ay * 32768 + rin) / (2 * rin));
        end else if (e.zone == ZONE_RING) begin
            e.warning = 1'b1;
            if (d2sq != 0) begin
                r = root_floor(d2sq << 16);
                mx = clip_mag(((ax << 24) + r) / (2 * r));
                my = clip_mag(((ay << 24) + r) / (2 * r));
            end
        end
        e.axis_x = (dx2 < 0) ? AXW'(-mx) : AXW'(mx);
        e.axis_y = (dy2 > 0) ? AXW'(-my) : AXW'(my);
        return e;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // driver: one touch beat per accepted start
    always @(posedge i_clk) begin
        if (start && !busy) begin
            t_touch t;
            t.active = i_touch_active;
            t.x = i_touch_x;
            t.y = i_touch_y;
            joy_q.push_back(map_touch(t));
        end
        if (start && busy) begin
            // hold the beat
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
        end else if (touch_q.size() > 0) begin
            t_touch n;
            n = touch_q.pop_front();
            start <= 1'b1;
            i_touch_active <= n.active;
            i_touch_x <= n.x;
            i_touch_y <= n.y;
            gap_left <= pick_gap();
        end else begin
            start <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, joy_q.size());
            $display("*** FAILED ***");
            $finish;
        end
        if (o_done) begin
            if (joy_q.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected result beat at cycle %0d", cycles);
            end else begin
                t_joy e;
                e = joy_q.pop_front();
                n_results <= n_results + 1;
                if (e.zone == ZONE_RING) n_ring <= n_ring + 1;
                if (o_zone !== e.zone || o_warning !== e.warning || o_knob_x !== e.knob_x ||
                    o_knob_y !== e.knob_y || o_axis_x !== e.axis_x ||
                    o_axis_y !== e.axis_y) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display({"mismatch: exp z%0d w%0d k(%0d,%0d) a(%0d,%0d)",
                                  " got z%0d w%0d k(%0d,%0d) a(%0d,%0d)"},
                                 e.zone, e.warning, $signed(e.knob_x), $signed(e.knob_y),
                                 $signed(e.axis_x), $signed(e.axis_y), o_zone, o_warning,
                                 o_knob_x, o_knob_y, o_axis_x, o_axis_y);
                end
            end
        end
    end

    // valid stays high across a burst of writes; run_phase drops it
    task automatic write_reg(logic [CIW-1:0] idx, logic [COORD_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ORIGIN_X: cur_cfg.origin_x = data;
            CFG_ORIGIN_Y: cur_cfg.origin_y = data;
            CFG_BOX_W:    cur_cfg.box_width = data;
            CFG_KNOB_R:   cur_cfg.knob_radius = data[KR_BITS-1:0];
            CFG_RING_W:   cur_cfg.ring_width = data;
            default: ;
        endcase
    endtask

    task automatic setup(int ox, int oy, int bw, int kr, int rw);
        write_reg(CFG_ORIGIN_X, COORD_BITS'(ox));
        write_reg(CFG_ORIGIN_Y, COORD_BITS'(oy));
        write_reg(CFG_BOX_W, COORD_BITS'(bw));
        write_reg(CFG_KNOB_R, COORD_BITS'(kr));
        write_reg(CFG_RING_W, COORD_BITS'(rw));
    endtask

    task automatic add_touch(bit act, int x, int y);
        t_touch t;
        t.active = act;
        t.x = COORD_BITS'((x < 0) ? 0 : (x > 4095) ? 4095 : x);
        t.y = COORD_BITS'((y < 0) ? 0 : (y > 4095) ? 4095 : y);
        touch_q.push_back(t);
    endtask

    // well-formed touches around the stick plus boundary hits and full-range noise
    task automatic add_random(int n);
        int px, py, span, rr, p;
        px = cur_cfg.origin_x + cur_cfg.box_width / 2;
        py = cur_cfg.origin_y + cur_cfg.box_width / 2;
        rr = cur_cfg.box_width / 2;
        span = rr + cur_cfg.ring_width + 4;
        add_touch(1'b1, px, py);
        add_touch(1'b1, px + rr, py);
        add_touch(1'b1, px, py - rr - cur_cfg.ring_width);
        add_touch(1'b1, px - rr - cur_cfg.ring_width - 1, py);
        repeat (n) begin
            p = $urandom_range(0, 99);
            if (p < 75)
                add_touch($urandom_range(0, 9) != 0,
                          px + $urandom_range(0, 2 * span) - span,
                          py + $urandom_range(0, 2 * span) - span);
            else
                add_touch(1'($urandom_range(0, 1)), $urandom_range(0, 4095),
                          $urandom_range(0, 4095));
        end
    endtask

    task automatic run_phase();
        i_cfg_valid <= 1'b0;
        while (touch_q.size() > 0 || start || joy_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        n_phases++;
    endtask

    initial begin
        cur_cfg.origin_x = 0;
        cur_cfg.origin_y = 0;
        cur_cfg.box_width = 100;
        cur_cfg.knob_radius = 10;
        cur_cfg.ring_width = 10;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: centre (50,50), radius 50, ring out to 60
        add_touch(1'b0, 4095, 4095);
        add_touch(1'b1, 50, 50);
        add_touch(1'b1, 60, 50);
        add_touch(1'b1, 50, 99);
        add_touch(1'b1, 100, 50);
        add_touch(1'b1, 110, 50);
        add_touch(1'b1, 111, 50);
        add_touch(1'b1, 92, 92);
        add_touch(1'b1, 0, 0);
        add_touch(1'b1, 4095, 4095);
        add_touch(1'b1, 0, 4095);
        add_touch(1'b1, 9, 5);
        add_random(70);
        run_phase();

        setup(0, 0, 0, 0, 0);
        add_touch(1'b1, 0, 0);
        add_touch(1'b1, 1, 0);
        add_random(60);
        run_phase();

        setup(4095, 4095, 4095, 2047, 4095);
        add_random(70);
        run_phase();

        setup(2000, 1000, 1, 5, 3);
        add_random(70);
        run_phase();

        setup(100, 3000, 2, 4095, 0);
        for (int k = 1; k <= 3; k++)
            write_reg(CIW'(CFG_RING_W + k), COORD_BITS'($urandom_range(0, 4095)));
        add_random(70);
        run_phase();

        setup(1000, 1000, 400, 30, 50);
        add_random(90);
        run_phase();

        repeat (2) begin
            setup($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(2, 4095),
                  $urandom_range(0, 4095), $urandom_range(0, 300));
            add_random(80);
            run_phase();
        end

        $display("covered %0d register settings, %0d results checked (%0d in the ring)",
                 n_phases, n_results, n_ring);
        if (mismatches == 0 && joy_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
